// ===== rtl/core/i2cem_pkg.sv =====
// shared types and constants for the i2c eeprom master core
package i2cem_pkg;

    // bus phase codes, one per bit-phase tick position
    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ST_A   = 5'd1,
        PH_ST_B   = 5'd2,
        PH_DEVW_L = 5'd3,
        PH_DEVW_H = 5'd4,
        PH_ACK1_L = 5'd5,
        PH_ACK1_H = 5'd6,
        PH_ADDR_L = 5'd7,
        PH_ADDR_H = 5'd8,
        PH_ACK2_L = 5'd9,
        PH_ACK2_H = 5'd10,
        PH_DATA_L = 5'd11,
        PH_DATA_H = 5'd12,
        PH_ACK3_L = 5'd13,
        PH_ACK3_H = 5'd14,
        PH_RS_A   = 5'd15,
        PH_RS_B   = 5'd16,
        PH_RS_C   = 5'd17,
        PH_DEVR_L = 5'd18,
        PH_DEVR_H = 5'd19,
        PH_ACK4_L = 5'd20,
        PH_ACK4_H = 5'd21,
        PH_RD_L   = 5'd22,
        PH_RD_H   = 5'd23,
        PH_NK_L   = 5'd24,
        PH_NK_H   = 5'd25,
        PH_SP_A   = 5'd26,
        PH_SP_B   = 5'd27,
        PH_SP_C   = 5'd28
    } phase_t;

    // register indexes on the configuration port
    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_ACK_TIMEOUT    = 1'b1;

    // register reset values
    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;
    localparam logic [7:0] ACK_TIMEOUT_RESET    = 8'd250;

    // read/write bit of the address byte
    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    // kind codes of a request
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // one result item
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } result_t;

endpackage

// ===== rtl/core/i2c_eeprom_master_core.sv =====
// i2c eeprom master core: tick-driven byte write and random read sequencer
//
// Each input item is one bit-phase tick from an external divider and gives exactly one
// result item carrying the SCL/SDA drive for that tick, busy, done, the last read byte
// and the missing-acknowledge flag. One item is taken per clock cycle unless stalled: the
// phase state machine advances once per accepted item; its next state and result are
// formed in one logic pass into the result register, which drains as the next item enters.
// A byte write takes 2 + 3*18 + 3 = 59 ticks plus any acknowledge wait; a random read
// takes 2 + 2*18 + 3 + 18 + 16 + 2 + 3 = 80 ticks plus any acknowledge wait. Each
// acknowledge slot holds SCL high for up to ack_timeout ticks, at least one; every tick
// beyond the first adds one to the totals. Registers: device_address at byte address 0,
// ack_timeout at byte address 4; both take effect at once; the user must write them only while idle.
module i2c_eeprom_master_core (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        request,
    input  logic        kind,
    input  logic [7:0]  word_address,
    input  logic [7:0]  write_data,
    input  logic        sda_in,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_level,
    output logic        sda_level,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_data,
    output logic        ack_missing,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cem_pkg::*;

    // configuration registers
    logic [6:0] device_address_reg;
    logic [7:0] ack_timeout_reg;

    // sequencer state
    phase_t     phase_reg,        phase_next;
    logic [2:0] bit_count_reg,    bit_count_next;
    logic [7:0] shift_reg_reg,    shift_reg_next;
    logic [7:0] ack_wait_reg,     ack_wait_next;
    logic       held_kind_reg,    held_kind_next;
    logic [7:0] held_address_reg, held_address_next;
    logic [7:0] held_data_reg,    held_data_next;
    logic [7:0] received_reg,     received_next;
    logic       nack_seen_reg,    nack_seen_next;

    // result register
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;

    logic       in_fire;
    logic       cfg_write;
    phase_t     cur_phase;
    logic       start_now;
    logic       scl_drive;
    logic       sda_drive;
    logic       done_drive;
    logic [8:0] ack_inc;
    logic       ack_end;
    logic [7:0] addr_byte_w;
    logic [7:0] addr_byte_r;

    // handshake
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= DEVICE_ADDRESS_RESET;
            ack_timeout_reg    <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_DEVICE_ADDRESS: device_address_reg <= pwdata[6:0];
                REG_ACK_TIMEOUT:    ack_timeout_reg    <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    // configuration read
    always_comb
    begin
        case (paddr[2])
            REG_DEVICE_ADDRESS: prdata = {25'd0, device_address_reg};
            REG_ACK_TIMEOUT:    prdata = {24'd0, ack_timeout_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // a request in idle starts the sequence on this very tick
    assign start_now   = (phase_reg == PH_IDLE) && request;
    assign cur_phase   = start_now ? PH_ST_A : phase_reg;
    assign addr_byte_w = {device_address_reg, RW_WRITE};
    assign addr_byte_r = {device_address_reg, RW_READ};

    // acknowledge slot ends on low sda or on timeout
    assign ack_inc = {1'b0, ack_wait_reg} + 9'd1;
    assign ack_end = !sda_in || (ack_inc >= {1'b0, ack_timeout_reg});

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shift_reg_next    = shift_reg_reg;
        ack_wait_next     = ack_wait_reg;
        held_kind_next    = held_kind_reg;
        held_address_next = held_address_reg;
        held_data_next    = held_data_reg;
        received_next     = received_reg;
        nack_seen_next    = nack_seen_reg;

        if (start_now)
        begin
            held_kind_next    = kind;
            held_address_next = word_address;
            held_data_next    = write_data;
            nack_seen_next    = 1'b0;
            ack_wait_next     = 8'd0;
            bit_count_next    = 3'd0;
        end

        case (cur_phase)
            PH_ST_A: phase_next = PH_ST_B;
            PH_ST_B:
            begin
                shift_reg_next = addr_byte_w;
                bit_count_next = 3'd0;
                phase_next     = PH_DEVW_L;
            end
            PH_DEVW_L: phase_next = PH_DEVW_H;
            PH_ADDR_L: phase_next = PH_ADDR_H;
            PH_DATA_L: phase_next = PH_DATA_H;
            PH_DEVR_L: phase_next = PH_DEVR_H;
            PH_DEVW_H, PH_ADDR_H, PH_DATA_H, PH_DEVR_H:
            begin
                if (bit_count_reg == 3'd7)
                begin
                    bit_count_next = 3'd0;
                    phase_next     = phase_t'(cur_phase + 5'd1);
                end
                else
                begin
                    bit_count_next = bit_count_reg + 3'd1;
                    shift_reg_next = {shift_reg_reg[6:0], 1'b0};
                    phase_next     = phase_t'(cur_phase - 5'd1);
                end
            end
            PH_ACK1_L: phase_next = PH_ACK1_H;
            PH_ACK2_L: phase_next = PH_ACK2_H;
            PH_ACK3_L: phase_next = PH_ACK3_H;
            PH_ACK4_L: phase_next = PH_ACK4_H;
            PH_ACK1_H, PH_ACK2_H, PH_ACK3_H, PH_ACK4_H:
            begin
                if (ack_end)
                begin
                    if (sda_in)
                    begin
                        nack_seen_next = 1'b1;
                    end
                    ack_wait_next  = 8'd0;
                    bit_count_next = 3'd0;
                    // pick the byte that follows this slot
                    case (cur_phase)
                        PH_ACK1_H:
                        begin
                            shift_reg_next = held_address_reg;
                            phase_next     = PH_ADDR_L;
                        end
                        PH_ACK2_H:
                        begin
                            if (held_kind_reg == KIND_READ)
                            begin
                                phase_next = PH_RS_A;
                            end
                            else
                            begin
                                shift_reg_next = held_data_reg;
                                phase_next     = PH_DATA_L;
                            end
                        end
                        PH_ACK4_H:
                        begin
                            shift_reg_next = 8'd0;
                            phase_next     = PH_RD_L;
                        end
                        default: phase_next = PH_SP_A;
                    endcase
                end
                else
                begin
                    ack_wait_next = ack_inc[7:0];
                end
            end
            PH_RS_A: phase_next = PH_RS_B;
            PH_RS_B: phase_next = PH_RS_C;
            PH_RS_C:
            begin
                shift_reg_next = addr_byte_r;
                bit_count_next = 3'd0;
                phase_next     = PH_DEVR_L;
            end
            PH_RD_L: phase_next = PH_RD_H;
            PH_RD_H:
            begin
                shift_reg_next = {shift_reg_reg[6:0], sda_in};
                if (bit_count_reg == 3'd7)
                begin
                    bit_count_next = 3'd0;
                    received_next  = {shift_reg_reg[6:0], sda_in};
                    phase_next     = PH_NK_L;
                end
                else
                begin
                    bit_count_next = bit_count_reg + 3'd1;
                    phase_next     = PH_RD_L;
                end
            end
            PH_NK_L: phase_next = PH_NK_H;
            PH_NK_H: phase_next = PH_SP_A;
            PH_SP_A: phase_next = PH_SP_B;
            PH_SP_B: phase_next = PH_SP_C;
            PH_SP_C: phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    // line drive for this tick
    always_comb
    begin
        scl_drive  = 1'b1;
        sda_drive  = 1'b1;
        done_drive = 1'b0;
        case (cur_phase)
            PH_ST_B, PH_RS_C: sda_drive = 1'b0;
            PH_DEVW_L, PH_ADDR_L, PH_DATA_L, PH_DEVR_L:
            begin
                scl_drive = 1'b0;
                sda_drive = shift_reg_reg[7];
            end
            PH_DEVW_H, PH_ADDR_H, PH_DATA_H, PH_DEVR_H: sda_drive = shift_reg_reg[7];
            PH_ACK1_L, PH_ACK2_L, PH_ACK3_L, PH_ACK4_L: scl_drive = 1'b0;
            PH_RS_A, PH_RD_L, PH_NK_L: scl_drive = 1'b0;
            PH_SP_A:
            begin
                scl_drive = 1'b0;
                sda_drive = 1'b0;
            end
            PH_SP_B: sda_drive = 1'b0;
            PH_SP_C: done_drive = 1'b1;
            default: ;
        endcase
    end

    // result item
    always_comb
    begin
        result_next.scl_level   = scl_drive;
        result_next.sda_level   = sda_drive;
        result_next.busy_res    = (phase_next != PH_IDLE);
        result_next.done_res    = done_drive;
        result_next.read_data   = received_next;
        result_next.ack_missing = nack_seen_next;
    end

    // state registers, advanced once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= 3'd0;
            shift_reg_reg    <= 8'd0;
            ack_wait_reg     <= 8'd0;
            held_kind_reg    <= 1'b0;
            held_address_reg <= 8'd0;
            held_data_reg    <= 8'd0;
            received_reg     <= 8'd0;
            nack_seen_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_reg_reg    <= shift_reg_next;
            ack_wait_reg     <= ack_wait_next;
            held_kind_reg    <= held_kind_next;
            held_address_reg <= held_address_next;
            held_data_reg    <= held_data_next;
            received_reg     <= received_next;
            nack_seen_reg    <= nack_seen_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign scl_level   = result_reg.scl_level;
    assign sda_level   = result_reg.sda_level;
    assign busy_res    = result_reg.busy_res;
    assign done_res    = result_reg.done_res;
    assign read_data   = result_reg.read_data;
    assign ack_missing = result_reg.ack_missing;

    // the stop tick always ends the transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.done_res |-> !result_reg.busy_res)
        else $error("done item reports busy");

    // a request taken in idle moves straight on to the second start tick
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (phase_reg == PH_IDLE) && request |=> phase_reg == PH_ST_B)
        else $error("start sequence not entered");

    // the wait counter only runs inside an acknowledge high slot
    assert property (@(posedge clk) disable iff (!rst_n)
        ack_wait_reg != 8'd0 |-> (phase_reg == PH_ACK1_H) || (phase_reg == PH_ACK2_H)
            || (phase_reg == PH_ACK3_H) || (phase_reg == PH_ACK4_H))
        else $error("ack wait count outside acknowledge slot");

    // the bit counter only runs while a byte is shifted
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg != 3'd0 |-> (phase_reg == PH_DEVW_L) || (phase_reg == PH_DEVW_H)
            || (phase_reg == PH_ADDR_L) || (phase_reg == PH_ADDR_H)
            || (phase_reg == PH_DATA_L) || (phase_reg == PH_DATA_H)
            || (phase_reg == PH_DEVR_L) || (phase_reg == PH_DEVR_H)
            || (phase_reg == PH_RD_L) || (phase_reg == PH_RD_H))
        else $error("bit count outside a byte");

endmodule
